// ===== hdl/lacd_pkg.sv =====
package lacd_pkg;

  // Field widths
  localparam int unsigned RawW    = 16;
  localparam int unsigned MgW     = 12;
  localparam int unsigned ThrW    = 11;
  localparam int unsigned CntW    = 4;
  localparam int unsigned AxisW   = 2;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 11;

  // raw * 61 / 1000 == (|raw| * ScaleRecip) >> ScaleShift for |raw| <= 2^15
  localparam int unsigned RecipW     = 22;
  localparam int unsigned ScaleShift = 26;
  localparam logic [RecipW-1:0] ScaleRecip = 22'd4093641;

  // Register reset values
  localparam logic [AxisW-1:0] AxisSelRst = 2'd1;
  localparam logic [ThrW-1:0]  OnThrRst   = 11'd200;
  localparam logic [ThrW-1:0]  OffThrRst  = 11'd120;
  localparam logic [CntW-1:0]  OnCntRst   = 4'd3;
  localparam logic [CntW-1:0]  OffCntRst  = 4'd5;

  typedef enum logic [AxisW-1:0] {
    AxisX = 2'd0,
    AxisY = 2'd1,
    AxisZ = 2'd2
  } axis_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgAxisSel = 3'd0,
    CfgOnThr   = 3'd1,
    CfgOffThr  = 3'd2,
    CfgOnCnt   = 3'd3,
    CfgOffCnt  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [AxisW-1:0] axis_sel;
    logic [ThrW-1:0]  on_thr;
    logic [ThrW-1:0]  off_thr;
    logic [CntW-1:0]  on_cnt;
    logic [CntW-1:0]  off_cnt;
  } cfg_t;

  typedef struct packed {
    logic                  active;
    logic                  entered;
    logic                  cleared;
    logic signed [MgW-1:0] filtered;
    logic signed [MgW-1:0] x_mg;
    logic signed [MgW-1:0] y_mg;
    logic signed [MgW-1:0] z_mg;
  } res_t;

endpackage

// ===== hdl/lacd_scale.sv =====
module lacd_scale (
  input  logic signed [lacd_pkg::RawW-1:0] raw_i,
  output logic signed [lacd_pkg::MgW-1:0]  mg_o
);

  localparam int unsigned ProdW = lacd_pkg::RawW + lacd_pkg::RecipW;
  localparam int unsigned QW    = lacd_pkg::MgW - 1;

  logic                      neg;
  logic [lacd_pkg::RawW-1:0] mag;
  logic [ProdW-1:0]          prod;
  logic [QW-1:0]             quo;
  logic [lacd_pkg::MgW-1:0]  quo_ext;

  assign neg  = raw_i[lacd_pkg::RawW-1];
  // -(-32768) wraps to 16'h8000, which is the right magnitude unsigned
  assign mag  = neg ? (~raw_i + 1'b1) : raw_i;
  assign prod = ProdW'(mag) * ProdW'(lacd_pkg::ScaleRecip);
  assign quo  = prod[lacd_pkg::ScaleShift +: QW];
  assign quo_ext = {1'b0, quo};
  // truncation toward zero: scale the magnitude, then restore the sign
  assign mg_o = neg ? signed'(~quo_ext + 1'b1) : signed'(quo_ext);

endmodule

// ===== hdl/lacd_core.sv =====
module lacd_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            step_i,
  input  logic                            sample_valid_i,
  input  logic signed [lacd_pkg::MgW-1:0] x_mg_i,
  input  logic signed [lacd_pkg::MgW-1:0] y_mg_i,
  input  logic signed [lacd_pkg::MgW-1:0] z_mg_i,
  input  lacd_pkg::cfg_t                  cfg_i,
  output lacd_pkg::res_t                  res_o
);

  localparam int unsigned DiffW = lacd_pkg::MgW + 1;

  logic signed [lacd_pkg::MgW-1:0] filt_q, filt_d;
  logic                            seeded_q, seeded_d;
  logic                            corner_q, corner_d;
  logic [lacd_pkg::CntW-1:0]       entry_q, entry_d;
  logic [lacd_pkg::CntW-1:0]       exit_q, exit_d;
  logic signed [lacd_pkg::MgW-1:0] x_q, x_d, y_q, y_d, z_q, z_d;

  logic signed [lacd_pkg::MgW-1:0] lat;
  logic signed [DiffW-1:0]         diff;
  logic signed [DiffW-1:0]         diff_adj;
  logic signed [DiffW-1:0]         step_amt;
  logic [lacd_pkg::MgW-1:0]        mag;
  logic                            entered, cleared;

  always_comb begin
    case (lacd_pkg::axis_e'(cfg_i.axis_sel))
      lacd_pkg::AxisX: lat = x_mg_i;
      lacd_pkg::AxisZ: lat = z_mg_i;
      default:         lat = y_mg_i;
    endcase
  end

  // (lat - filt) / 4, rounded toward zero
  assign diff     = DiffW'(lat) - DiffW'(filt_q);
  assign diff_adj = diff + (diff[DiffW-1] ? DiffW'(3) : DiffW'(0));
  assign step_amt = diff_adj >>> 2;

  always_comb begin
    filt_d   = filt_q;
    seeded_d = seeded_q;
    corner_d = corner_q;
    entry_d  = entry_q;
    exit_d   = exit_q;
    x_d      = x_q;
    y_d      = y_q;
    z_d      = z_q;
    entered  = 1'b0;
    cleared  = 1'b0;

    if (sample_valid_i) begin
      x_d      = x_mg_i;
      y_d      = y_mg_i;
      z_d      = z_mg_i;
      seeded_d = 1'b1;
      filt_d   = seeded_q ? (filt_q + step_amt[lacd_pkg::MgW-1:0]) : lat;
    end

    mag = filt_d[lacd_pkg::MgW-1] ? (~filt_d + 1'b1) : filt_d;

    if (sample_valid_i) begin
      if (!corner_q) begin
        if (mag >= {1'b0, cfg_i.on_thr}) begin
          if (entry_q < cfg_i.on_cnt) begin
            entry_d = entry_q + 1'b1;
          end
        end else begin
          entry_d = '0;
        end
        if (entry_d >= cfg_i.on_cnt) begin
          corner_d = 1'b1;
          exit_d   = '0;
          entered  = 1'b1;
        end
      end else begin
        if (mag <= {1'b0, cfg_i.off_thr}) begin
          if (exit_q < cfg_i.off_cnt) begin
            exit_d = exit_q + 1'b1;
          end
        end else begin
          exit_d = '0;
        end
        if (exit_d >= cfg_i.off_cnt) begin
          corner_d = 1'b0;
          entry_d  = '0;
          cleared  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q   <= '0;
      seeded_q <= 1'b0;
      corner_q <= 1'b0;
      entry_q  <= '0;
      exit_q   <= '0;
      x_q      <= '0;
      y_q      <= '0;
      z_q      <= '0;
    end else if (step_i) begin
      filt_q   <= filt_d;
      seeded_q <= seeded_d;
      corner_q <= corner_d;
      entry_q  <= entry_d;
      exit_q   <= exit_d;
      x_q      <= x_d;
      y_q      <= y_d;
      z_q      <= z_d;
    end
  end

  always_comb begin
    res_o.active   = corner_d;
    res_o.entered  = entered;
    res_o.cleared  = cleared;
    res_o.filtered = filt_d;
    res_o.x_mg     = x_d;
    res_o.y_mg     = y_d;
    res_o.z_mg     = z_d;
  end

endmodule

// ===== hdl/lateral_accel_corner_detector_top.sv =====
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    sample_valid_i, raw_x_i, raw_y_i, raw_z_i
// out       output     out_valid_o / out_stall_i  corner_*_o, lateral_filtered_o, accel_*_mg_o
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; each input transfer is registered as a raw
// sample, then in milli-g (one constant multiply per axis), then as the filter/detector result.
// Reset clears the filter, detector and held accelerations and loads register defaults.
// Each stage takes a new item when it is empty or its successor moves, so a stalled
// output fills the bubbles ahead of it before in_stall_o rises.
module lateral_accel_corner_detector_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,

  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 sample_valid_i,
  input  logic signed [lacd_pkg::RawW-1:0]     raw_x_i,
  input  logic signed [lacd_pkg::RawW-1:0]     raw_y_i,
  input  logic signed [lacd_pkg::RawW-1:0]     raw_z_i,

  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 corner_active_o,
  output logic                                 corner_entered_o,
  output logic                                 corner_cleared_o,
  output logic signed [lacd_pkg::MgW-1:0]      lateral_filtered_o,
  output logic signed [lacd_pkg::MgW-1:0]      accel_x_mg_o,
  output logic signed [lacd_pkg::MgW-1:0]      accel_y_mg_o,
  output logic signed [lacd_pkg::MgW-1:0]      accel_z_mg_o,

  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lacd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [lacd_pkg::CfgDatW-1:0]         cfg_data_i
);

  lacd_pkg::cfg_t cfg_q;

  // stage 1: raw sample
  logic                            s1_vld_q;
  logic                            s1_sv_q;
  logic signed [lacd_pkg::RawW-1:0] s1_x_q, s1_y_q, s1_z_q;

  // stage 2: milli-g
  logic                            s2_vld_q;
  logic                            s2_sv_q;
  logic signed [lacd_pkg::MgW-1:0] s2_x_q, s2_y_q, s2_z_q;
  logic signed [lacd_pkg::MgW-1:0] x_mg, y_mg, z_mg;

  // result register
  logic                            out_vld_q;
  lacd_pkg::res_t                  res_q;
  lacd_pkg::res_t                  res;

  logic out_rdy, s2_rdy, s1_rdy;
  logic s2_adv, s1_adv, in_xfer;

  assign out_rdy  = !out_vld_q || !out_stall_i;
  assign s2_adv   = s2_vld_q && out_rdy;
  assign s2_rdy   = !s2_vld_q || out_rdy;
  assign s1_adv   = s1_vld_q && s2_rdy;
  assign s1_rdy   = !s1_vld_q || s2_rdy;
  assign in_xfer  = in_valid_i && s1_rdy;

  assign in_stall_o  = !s1_rdy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_sel <= lacd_pkg::AxisSelRst;
      cfg_q.on_thr   <= lacd_pkg::OnThrRst;
      cfg_q.off_thr  <= lacd_pkg::OffThrRst;
      cfg_q.on_cnt   <= lacd_pkg::OnCntRst;
      cfg_q.off_cnt  <= lacd_pkg::OffCntRst;
    end else if (cfg_valid_i) begin
      case (lacd_pkg::cfg_idx_e'(cfg_index_i))
        lacd_pkg::CfgAxisSel: cfg_q.axis_sel <= cfg_data_i[lacd_pkg::AxisW-1:0];
        lacd_pkg::CfgOnThr:   cfg_q.on_thr   <= cfg_data_i[lacd_pkg::ThrW-1:0];
        lacd_pkg::CfgOffThr:  cfg_q.off_thr  <= cfg_data_i[lacd_pkg::ThrW-1:0];
        lacd_pkg::CfgOnCnt:   cfg_q.on_cnt   <= cfg_data_i[lacd_pkg::CntW-1:0];
        lacd_pkg::CfgOffCnt:  cfg_q.off_cnt  <= cfg_data_i[lacd_pkg::CntW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_vld_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_vld_q <= s1_vld_q;
      end
      if (out_rdy) begin
        out_vld_q <= s2_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_sv_q <= sample_valid_i;
      s1_x_q  <= raw_x_i;
      s1_y_q  <= raw_y_i;
      s1_z_q  <= raw_z_i;
    end
    if (s1_adv) begin
      s2_sv_q <= s1_sv_q;
      s2_x_q  <= x_mg;
      s2_y_q  <= y_mg;
      s2_z_q  <= z_mg;
    end
    if (s2_adv) begin
      res_q <= res;
    end
  end

  lacd_scale u_scale_x (
    .raw_i (s1_x_q),
    .mg_o  (x_mg)
  );

  lacd_scale u_scale_y (
    .raw_i (s1_y_q),
    .mg_o  (y_mg)
  );

  lacd_scale u_scale_z (
    .raw_i (s1_z_q),
    .mg_o  (z_mg)
  );

  lacd_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (s2_adv),
    .sample_valid_i (s2_sv_q),
    .x_mg_i         (s2_x_q),
    .y_mg_i         (s2_y_q),
    .z_mg_i         (s2_z_q),
    .cfg_i          (cfg_q),
    .res_o          (res)
  );

  assign out_valid_o        = out_vld_q;
  assign corner_active_o    = res_q.active;
  assign corner_entered_o   = res_q.entered;
  assign corner_cleared_o   = res_q.cleared;
  assign lateral_filtered_o = res_q.filtered;
  assign accel_x_mg_o       = res_q.x_mg;
  assign accel_y_mg_o       = res_q.y_mg;
  assign accel_z_mg_o       = res_q.z_mg;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import lacd_pkg::*;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned TailCycles  = 12;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned PhaseItems  = 68;
  localparam int          MgNum       = 61;
  localparam int          MgDen       = 1000;
  localparam int          FltDiv      = 4;
  localparam logic [AxisW-1:0] AxisUnused = 2'd3;

  // one row of the directed plan: either a register write or a sample
  typedef struct packed {
    logic                   is_reg;
    cfg_idx_e               idx;
    logic [CfgDatW-1:0]     val;
    logic                   ok;
    logic signed [RawW-1:0] x;
    logic signed [RawW-1:0] y;
    logic signed [RawW-1:0] z;
    logic                   typed;
    res_t                   want;
  } step_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic                   sample_valid_i;
  logic signed [RawW-1:0] raw_x_i;
  logic signed [RawW-1:0] raw_y_i;
  logic signed [RawW-1:0] raw_z_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic                   corner_active_o;
  logic                   corner_entered_o;
  logic                   corner_cleared_o;
  logic signed [MgW-1:0]  lateral_filtered_o;
  logic signed [MgW-1:0]  accel_x_mg_o;
  logic signed [MgW-1:0]  accel_y_mg_o;
  logic signed [MgW-1:0]  accel_z_mg_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CfgIdxW-1:0]     cfg_index_i;
  logic [CfgDatW-1:0]     cfg_data_i;

  lateral_accel_corner_detector_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .sample_valid_i    (sample_valid_i),
    .raw_x_i           (raw_x_i),
    .raw_y_i           (raw_y_i),
    .raw_z_i           (raw_z_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .corner_active_o   (corner_active_o),
    .corner_entered_o  (corner_entered_o),
    .corner_cleared_o  (corner_cleared_o),
    .lateral_filtered_o(lateral_filtered_o),
    .accel_x_mg_o      (accel_x_mg_o),
    .accel_y_mg_o      (accel_y_mg_o),
    .accel_z_mg_o      (accel_z_mg_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i)
  );

  // detector mirror
  cfg_t                  cfg_m;
  logic signed [MgW-1:0] flt_mg;
  logic                  seeded;
  logic                  in_corner;
  logic [CntW-1:0]       entry_cnt;
  logic [CntW-1:0]       exit_cnt;
  logic signed [MgW-1:0] held_mg [3];

  res_t pending_res [$];

  bit send_idle_en = 1'b0;
  bit recv_idle_en = 1'b0;
  bit hold_req     = 1'b0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int n_items      = 0;
  int n_invalid    = 0;
  int n_checked    = 0;
  int n_enter      = 0;
  int n_exit       = 0;
  int n_writes     = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int counts_to_mg(logic signed [RawW-1:0] raw);
    return (int'(raw) * MgNum) / MgDen;
  endfunction

  function automatic res_t step_corner(logic ok, logic signed [RawW-1:0] x,
                                       logic signed [RawW-1:0] y,
                                       logic signed [RawW-1:0] z);
    int   lat;
    int   f;
    int   mag;
    res_t r;
    r.entered = 1'b0;
    r.cleared = 1'b0;
    if (ok) begin
      held_mg[0] = MgW'(counts_to_mg(x));
      held_mg[1] = MgW'(counts_to_mg(y));
      held_mg[2] = MgW'(counts_to_mg(z));
      case (cfg_m.axis_sel)
        AxisX: lat = int'(held_mg[0]);
        AxisZ: lat = int'(held_mg[2]);
        default: lat = int'(held_mg[1]);
      endcase
      if (!seeded) begin
        f = lat;
        seeded = 1'b1;
      end else begin
        f = int'(flt_mg) + (lat - int'(flt_mg)) / FltDiv;
      end
      flt_mg = MgW'(f);
      mag = (f < 0) ? -f : f;
      if (!in_corner) begin
        if (mag >= int'(cfg_m.on_thr)) begin
          if (entry_cnt < cfg_m.on_cnt) entry_cnt++;
        end else begin
          entry_cnt = '0;
        end
        if (entry_cnt >= cfg_m.on_cnt) begin
          in_corner = 1'b1;
          exit_cnt  = '0;
          r.entered = 1'b1;
          n_enter++;
        end
      end else begin
        if (mag <= int'(cfg_m.off_thr)) begin
          if (exit_cnt < cfg_m.off_cnt) exit_cnt++;
        end else begin
          exit_cnt = '0;
        end
        if (exit_cnt >= cfg_m.off_cnt) begin
          in_corner = 1'b0;
          entry_cnt = '0;
          r.cleared = 1'b1;
          n_exit++;
        end
      end
    end
    r.active   = in_corner;
    r.filtered = flt_mg;
    r.x_mg     = held_mg[0];
    r.y_mg     = held_mg[1];
    r.z_mg     = held_mg[2];
    return r;
  endfunction

  function automatic res_t mk_res(logic a, logic e, logic c, int f, int x, int y, int z);
    res_t r;
    r.active   = a;
    r.entered  = e;
    r.cleared  = c;
    r.filtered = MgW'(f);
    r.x_mg     = MgW'(x);
    r.y_mg     = MgW'(y);
    r.z_mg     = MgW'(z);
    return r;
  endfunction

  function automatic step_t smp(logic ok, logic signed [RawW-1:0] x,
                                logic signed [RawW-1:0] y, logic signed [RawW-1:0] z);
    step_t s;
    s    = '0;
    s.ok = ok;
    s.x  = x;
    s.y  = y;
    s.z  = z;
    return s;
  endfunction

  function automatic step_t smp_t(logic ok, logic signed [RawW-1:0] x,
                                  logic signed [RawW-1:0] y, logic signed [RawW-1:0] z,
                                  res_t want);
    step_t s;
    s       = smp(ok, x, y, z);
    s.typed = 1'b1;
    s.want  = want;
    return s;
  endfunction

  function automatic step_t reg_w(cfg_idx_e idx, logic [CfgDatW-1:0] val);
    step_t s;
    s        = '0;
    s.is_reg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    return s;
  endfunction

  function automatic logic signed [RawW-1:0] near_level(int lvl);
    int v;
    v = lvl + int'($urandom_range(0, 1600)) - 800;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return RawW'(v);
  endfunction

  function automatic void cmp_field(string nm, logic signed [MgW-1:0] want,
                                    logic signed [MgW-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", nm, want, got);
      err_cnt++;
    end
  endfunction

  // all tasks below start and end on a falling edge
  task automatic send_sample(logic ok, logic signed [RawW-1:0] x,
                             logic signed [RawW-1:0] y, logic signed [RawW-1:0] z,
                             logic typed, res_t want);
    res_t pred;
    int   gap;
    gap = (send_idle_en && $urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    sample_valid_i = ok;
    raw_x_i        = x;
    raw_y_i        = y;
    raw_z_i        = z;
    do @(posedge clk_i); while (in_stall_o);
    pred = step_corner(ok, x, y, z);
    pending_res.push_back(typed ? want : pred);
    n_items++;
    if (!ok) n_invalid++;
    @(negedge clk_i);
  endtask

  task automatic drain_pipe();
    in_valid_i = 1'b0;
    while (pending_res.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgDatW-1:0] val);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CfgAxisSel: cfg_m.axis_sel = val[AxisW-1:0];
      CfgOnThr:   cfg_m.on_thr   = val[ThrW-1:0];
      CfgOffThr:  cfg_m.off_thr  = val[ThrW-1:0];
      CfgOnCnt:   cfg_m.on_cnt   = val[CntW-1:0];
      CfgOffCnt:  cfg_m.off_cnt  = val[CntW-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // result side: random stall bursts, plus one long hold-off on request
  initial begin : sink
    int stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req    = 1'b0;
      end else if (stall_left > 0) begin
        out_stall_i = 1'b1;
        stall_left--;
      end else begin
        out_stall_i = 1'b0;
        if (recv_idle_en && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk_i) begin : chk
    res_t got;
    res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{corner_active_o, corner_entered_o, corner_cleared_o, lateral_filtered_o,
              accel_x_mg_o, accel_y_mg_o, accel_z_mg_o};
      if (pending_res.size() == 0) begin
        $error("result transfer with nothing pending");
        err_cnt++;
      end else begin
        want = pending_res.pop_front();
        n_checked++;
        cmp_field("corner_active", MgW'(want.active), MgW'(got.active));
        cmp_field("corner_entered", MgW'(want.entered), MgW'(got.entered));
        cmp_field("corner_cleared", MgW'(want.cleared), MgW'(got.cleared));
        cmp_field("lateral_filtered", want.filtered, got.filtered);
        cmp_field("accel_x_mg", want.x_mg, got.x_mg);
        cmp_field("accel_y_mg", want.y_mg, got.y_mg);
        cmp_field("accel_z_mg", want.z_mg, got.z_mg);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LimitCycles) begin
      $display("lateral_accel_corner_detector_top verification failed");
      $finish;
    end
  end

  initial begin : stim
    step_t                  plan [$];
    int                     level;
    int                     thr_on;
    logic                   ok;
    logic signed [RawW-1:0] x;
    logic signed [RawW-1:0] y;
    logic signed [RawW-1:0] z;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    sample_valid_i = 1'b0;
    raw_x_i        = '0;
    raw_y_i        = '0;
    raw_z_i        = '0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CfgAxisSel;
    cfg_data_i     = '0;
    cfg_m          = '{AxisSelRst, OnThrRst, OffThrRst, OnCntRst, OffCntRst};
    flt_mg         = '0;
    seeded         = 1'b0;
    in_corner      = 1'b0;
    entry_cnt      = '0;
    exit_cnt       = '0;
    held_mg[0]     = '0;
    held_mg[1]     = '0;
    held_mg[2]     = '0;
    level          = 0;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // invalid sample before any data shows the reset values
    plan.push_back(smp_t(1'b0, 16'sh7fff, 16'sh8000, 16'sh1234, mk_res(0, 0, 0, 0, 0, 0, 0)));
    // full-scale seeds the filter, third one enters with the default count of 3
    plan.push_back(smp_t(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                         mk_res(0, 0, 0, 1998, 1998, 1998, 1998)));
    plan.push_back(smp(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff));
    plan.push_back(smp_t(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                         mk_res(1, 1, 0, 1998, 1998, 1998, 1998)));
    plan.push_back(smp_t(1'b0, 16'sh0000, 16'sh0000, 16'sh0000,
                         mk_res(1, 0, 0, 1998, 1998, 1998, 1998)));
    plan.push_back(smp(1'b1, 16'sh8000, 16'sh8000, 16'sh8000));
    // zero counts: leave and enter on the very next valid sample
    plan.push_back(reg_w(CfgOffCnt, 0));
    plan.push_back(smp(1'b1, 16'sh0000, 16'sh0000, 16'sh0000));
    plan.push_back(reg_w(CfgOnCnt, 0));
    plan.push_back(smp(1'b1, 16'sd16, -16'sd17, -16'sd1));
    // exit counter left above a lowered limit
    plan.push_back(reg_w(CfgOffThr, 2047));
    plan.push_back(reg_w(CfgOffCnt, 15));
    plan.push_back(smp(1'b1, 16'sd1000, -16'sd1000, 16'sd500));
    plan.push_back(smp(1'b1, -16'sd1000, 16'sd2500, 16'sd40));
    plan.push_back(smp(1'b1, 16'sd12345, -16'sd12345, 16'sd777));
    plan.push_back(reg_w(CfgOffCnt, 2));
    plan.push_back(smp(1'b1, 16'sd300, 16'sd300, 16'sd300));
    // same for the entry counter
    plan.push_back(reg_w(CfgOnThr, 0));
    plan.push_back(reg_w(CfgOnCnt, 15));
    plan.push_back(smp(1'b1, 16'sh5555, 16'shaaaa, 16'sh5555));
    plan.push_back(smp(1'b1, 16'shaaaa, 16'sh5555, 16'shaaaa));
    plan.push_back(smp(1'b1, 16'sh00ff, 16'shff00, 16'sh0f0f));
    plan.push_back(reg_w(CfgOnCnt, 1));
    plan.push_back(smp(1'b1, 16'shf0f0, 16'sh7ffe, 16'sh8001));
    // axis choice, including the unused code
    plan.push_back(reg_w(CfgAxisSel, CfgDatW'(AxisUnused)));
    plan.push_back(smp(1'b1, 16'sd100, 16'sd20000, -16'sd20000));
    plan.push_back(reg_w(CfgAxisSel, CfgDatW'(AxisX)));
    plan.push_back(smp(1'b1, -16'sd30000, 16'sd5, 16'sd5));
    plan.push_back(reg_w(CfgAxisSel, CfgDatW'(AxisZ)));
    plan.push_back(smp(1'b1, 16'sd5, 16'sd5, 16'sd30000));
    plan.push_back(smp(1'b0, 16'sh5555, 16'shaaaa, 16'sh0001));

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        drain_pipe();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_sample(plan[i].ok, plan[i].x, plan[i].y, plan[i].z, plan[i].typed,
                    plan[i].want);
      end
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      drain_pipe();
      case (ph)
        0: begin
          write_reg(CfgAxisSel, CfgDatW'(AxisX));
          write_reg(CfgOnThr, 0);
          write_reg(CfgOffThr, 0);
          write_reg(CfgOnCnt, 0);
          write_reg(CfgOffCnt, 0);
        end
        1: begin
          write_reg(CfgAxisSel, CfgDatW'(AxisZ));
          write_reg(CfgOnThr, 2047);
          write_reg(CfgOffThr, 2047);
          write_reg(CfgOnCnt, 15);
          write_reg(CfgOffCnt, 15);
        end
        default: begin
          thr_on = $urandom_range(40, 700);
          write_reg(CfgAxisSel, CfgDatW'($urandom_range(0, 3)));
          write_reg(CfgOnThr, CfgDatW'(thr_on));
          write_reg(CfgOffThr, CfgDatW'($urandom_range(0, thr_on)));
          write_reg(CfgOnCnt, CfgDatW'($urandom_range(0, 6)));
          write_reg(CfgOffCnt, CfgDatW'($urandom_range(0, 9)));
        end
      endcase
      // phase 2 runs back to back; the tail of the run has no idling at all
      send_idle_en = (ph < 6) && (ph != 2);
      recv_idle_en = send_idle_en;
      for (int i = 0; i < PhaseItems; i++) begin
        if (ph == 3 && i == 10) hold_req = 1'b1;
        ok = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 11) == 0) begin
          x = RawW'($urandom);
          y = RawW'($urandom);
          z = RawW'($urandom);
        end else begin
          // slowly changing lateral load: long runs above and below threshold
          if ($urandom_range(0, 15) == 0)
            level = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 64000)) - 32000;
          x = near_level(level);
          y = near_level(level);
          z = near_level(level);
        end
        send_sample(ok, x, y, z, 1'b0, '0);
      end
    end

    drain_pipe();
    repeat (TailCycles) @(posedge clk_i);
    $display("Sent %0d samples (%0d skipped), checked %0d results, %0d register writes.",
             n_items, n_invalid, n_checked, n_writes);
    $display("Detector saw %0d corner entries and %0d exits across %0d settings.",
             n_enter, n_exit, NumPhases);
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("lateral_accel_corner_detector_top verification clean");
    end else begin
      $display("lateral_accel_corner_detector_top verification failed");
    end
    $finish;
  end

endmodule
